[sv/mdw_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot dwell unit package
// Shared widths, register indexes, divider handshake types and saturation.
// ----------------------------------------------------------------------------
package mdw_pkg;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int MAP_W  = 46;
  localparam int SUM_W  = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_MIN_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_MIN_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_MAX_RE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_MAX_IM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_LIMIT   = 3'd5;

  typedef struct packed {
    logic                    start;
    logic signed [MAP_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [MAP_W:0] quot;
  } div_rsp_t;

  localparam logic signed [SUM_W-1:0] Q_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] Q_MIN = -48'sh0000_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > Q_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Q_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/mdw_mul.sv]
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered signed product per cycle, used for both window mapping and
// every squaring step of the iteration.
// ----------------------------------------------------------------------------
module mdw_mul (
  input  logic                              clk,
  input  logic signed [mdw_pkg::MUL_W-1:0]  a,
  input  logic signed [mdw_pkg::MUL_W-1:0]  b,
  output logic signed [mdw_pkg::PROD_W-1:0] p
);
  import mdw_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

[sv/mdw_div.sv]
// ----------------------------------------------------------------------------
// Iterative floor divider
// Restoring division, one quotient bit per cycle, of a signed dividend by an
// unsigned divisor, with the quotient rounded toward minus infinity.
// ----------------------------------------------------------------------------
module mdw_div #(
  parameter int DEN_W = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mdw_pkg::div_req_t   req,
  input  logic [DEN_W-1:0]    den,
  output mdw_pkg::div_rsp_t   rsp
);
  import mdw_pkg::*;

  localparam int CNT_W = $clog2(MAP_W);

  logic                  busy_r, fin_r, done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  neg_r;
  logic [MAP_W-1:0]      quo_r;
  logic [DEN_W:0]        rem_r;
  logic [DEN_W-1:0]      den_r;
  logic signed [MAP_W:0] q_r;

  logic [DEN_W:0]        shifted;
  logic                  ge;
  logic [MAP_W-1:0]      mag;
  logic [MAP_W:0]        qmag;

  assign shifted = {rem_r[DEN_W-1:0], quo_r[MAP_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign mag     = req.num[MAP_W-1] ? MAP_W'(-req.num) : MAP_W'(req.num);
  assign qmag    = {1'b0, quo_r} + {{MAP_W{1'b0}}, (rem_r != '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= req.num[MAP_W-1];
        quo_r  <= mag;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? (shifted - {1'b0, den_r}) : shifted;
        quo_r <= {quo_r[MAP_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAP_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        q_r    <= neg_r ? -$signed(qmag) : $signed({1'b0, quo_r});
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

[sv/mandelbrot_dwell_unit.sv]
// ----------------------------------------------------------------------------
// Mandelbrot dwell unit
// Maps a pixel into the complex window and counts escape-time iterations.
// ----------------------------------------------------------------------------
// The input stream carries one pixel per beat (column and row). The output
// stream returns one dwell count per pixel, in order. Window corners,
// resolution and dwell limit are written through the configuration port;
// the user must write them only while the unit is idle, as the unit itself
// does not enforce this. Each axis is mapped with one pass of the shared
// multiplier followed by the bit-serial divider. Each escape iteration then
// issues re*re, im*im and re*im on the shared multiplier and, unless the
// point has escaped, updates re and im. From accept to result in_tready
// stays low. The next pixel is accepted as soon as the result has been
// moved to the output register.
// When the receiver stalls, the result waits in the output register and the
// unit holds its final state until that register frees up.
// Reset loads the default window (-3.5..0.5, -1..1), a resolution of 512
// and a dwell limit of 514, and empties the output register.
// ----------------------------------------------------------------------------
module mandelbrot_dwell_unit #(
  parameter int MAX_RESOLUTION = 4096,
  parameter int DWELL_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // pixel_col[11:0], pixel_row[23:12]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,  // dwell[15:0]
  input  logic                             cfg_we,
  input  logic [mdw_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [31:0]                      cfg_wdata
);
  import mdw_pkg::*;

  localparam int RES_W = $clog2(MAX_RESOLUTION + 1);
  localparam int CNT_W = DWELL_BITS;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_MAP_RE  = 12'b0000_0000_0010,
    S_DIV_RE  = 12'b0000_0000_0100,
    S_WAIT_RE = 12'b0000_0000_1000,
    S_MAP_IM  = 12'b0000_0001_0000,
    S_DIV_IM  = 12'b0000_0010_0000,
    S_WAIT_IM = 12'b0000_0100_0000,
    S_CHK     = 12'b0000_1000_0000,
    S_RR      = 12'b0001_0000_0000,
    S_II      = 12'b0010_0000_0000,
    S_RI      = 12'b0100_0000_0000,
    S_OUT     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] min_re_r, min_im_r, max_re_r, max_im_r;
  logic [12:0]        res_r;
  logic [15:0]        limit_r;

  logic [11:0]        col_r, col_nxt, row_r, row_nxt;
  logic signed [31:0] c_re_r, c_re_nxt, c_im_r, c_im_nxt;
  logic signed [31:0] re_r, re_nxt, im_r, im_nxt;
  logic [63:0]        rr_r, rr_nxt;
  logic signed [63:0] diff_r, diff_nxt;
  logic               esc_r, esc_nxt;
  logic [CNT_W-1:0]   dwell_r, dwell_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_data_r, out_data_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic signed [MUL_W-1:0]  span_re, span_im;
  logic [RES_W-1:0]         res_eff;
  logic [32:0]              lim_wide, cap;
  logic [CNT_W-1:0]         limit_eff;
  logic [63:0]              ii;
  logic signed [39:0]       re_sh;
  logic signed [40:0]       im_sh;
  logic signed [31:0]       re_upd, im_upd, c_map;
  logic                     out_free;

  mdw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  mdw_div #(
    .DEN_W (RES_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .den   (res_eff),
    .rsp   (div_rsp)
  );

  assign span_re = MUL_W'(max_re_r) - MUL_W'(min_re_r);
  assign span_im = MUL_W'(max_im_r) - MUL_W'(min_im_r);

  always_comb begin
    if (res_r == '0) begin
      res_eff = RES_W'(1);
    end else if (32'(res_r) > 32'(MAX_RESOLUTION)) begin
      res_eff = RES_W'(MAX_RESOLUTION);
    end else begin
      res_eff = RES_W'(res_r);
    end
  end

  assign cap       = (33'd1 << DWELL_BITS) - 33'd1;
  assign lim_wide  = (33'(limit_r) > cap) ? cap : 33'(limit_r);
  assign limit_eff = CNT_W'(lim_wide);

  assign ii     = mul_p[63:0];
  assign re_sh  = diff_r[63:24];
  assign im_sh  = mul_p[63:23];
  assign re_upd = sat32(SUM_W'(re_sh) + SUM_W'(c_re_r));
  assign im_upd = sat32(SUM_W'(im_sh) + SUM_W'(c_im_r));
  assign c_map  = sat32(SUM_W'(state_r == S_WAIT_RE ? min_re_r : min_im_r)
                        + SUM_W'(div_rsp.quot));

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MAP_RE: begin
        mul_a = span_re;
        mul_b = MUL_W'(col_r);
      end
      S_MAP_IM: begin
        mul_a = span_im;
        mul_b = MUL_W'(row_r);
      end
      S_CHK: begin
        mul_a = MUL_W'(re_r);
        mul_b = MUL_W'(re_r);
      end
      S_RR: begin
        mul_a = MUL_W'(im_r);
        mul_b = MUL_W'(im_r);
      end
      S_II: begin
        mul_a = MUL_W'(re_r);
        mul_b = MUL_W'(im_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_req.start = (state_r == S_DIV_RE) || (state_r == S_DIV_IM);
  assign div_req.num   = mul_p[MAP_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    rr_nxt        = rr_r;
    diff_nxt      = diff_r;
    esc_nxt       = esc_r;
    dwell_nxt     = dwell_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          col_nxt   = in_tdata[11:0];
          row_nxt   = in_tdata[23:12];
          state_nxt = S_MAP_RE;
        end
      end
      S_MAP_RE: state_nxt = S_DIV_RE;
      S_DIV_RE: state_nxt = S_WAIT_RE;
      S_WAIT_RE: begin
        if (div_rsp.done) begin
          c_re_nxt  = c_map;
          re_nxt    = c_map;
          state_nxt = S_MAP_IM;
        end
      end
      S_MAP_IM: state_nxt = S_DIV_IM;
      S_DIV_IM: state_nxt = S_WAIT_IM;
      S_WAIT_IM: begin
        if (div_rsp.done) begin
          c_im_nxt  = c_map;
          im_nxt    = c_map;
          dwell_nxt = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: state_nxt = (dwell_r < limit_eff) ? S_RR : S_OUT;
      S_RR: begin
        rr_nxt    = mul_p[63:0];
        state_nxt = S_II;
      end
      S_II: begin
        esc_nxt   = (rr_r + ii) >= 64'h0010_0000_0000_0000;
        diff_nxt  = $signed(rr_r - ii);
        state_nxt = S_RI;
      end
      S_RI: begin
        if (esc_r) begin
          state_nxt = S_OUT;
        end else begin
          re_nxt    = re_upd;
          im_nxt    = im_upd;
          dwell_nxt = dwell_r + 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 16'(32'(dwell_r));
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    c_re_r     <= c_re_nxt;
    c_im_r     <= c_im_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    rr_r       <= rr_nxt;
    diff_r     <= diff_nxt;
    esc_r      <= esc_nxt;
    dwell_r    <= dwell_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_re_r <= -32'sd58720256;
      min_im_r <= -32'sd16777216;
      max_re_r <= 32'sd8388608;
      max_im_r <= 32'sd16777216;
      res_r    <= 13'd512;
      limit_r  <= 16'd514;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CORNER_MIN_RE: min_re_r <= cfg_wdata;
        REG_CORNER_MIN_IM: min_im_r <= cfg_wdata;
        REG_CORNER_MAX_RE: max_re_r <= cfg_wdata;
        REG_CORNER_MAX_IM: max_im_r <= cfg_wdata;
        REG_RESOLUTION:    res_r    <= cfg_wdata[12:0];
        REG_DWELL_LIMIT:   limit_r  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/mdw_checker.sv]
// ----------------------------------------------------------------------------
// Mandelbrot dwell unit port checker
// Watches the stream ports of the unit for handshake, stall and reset behavior.
// ----------------------------------------------------------------------------
module mdw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("unit ready again right after accepting a pixel");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while the unit was idle");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("unit not idle and empty after reset");

endmodule

bind mandelbrot_dwell_unit mdw_checker u_mdw_checker (.*);

[tb/sv/mandelbrot_dwell_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot dwell unit testbench
// Sends pixel beats through the input stream and checks every dwell count
// against a fixed-point escape-time predictor kept inside the testbench.
// Directed tests cover the reset window, corner and resolution extremes, the
// dwell limit extremes, writes to unused register indexes and one long output
// stall. A random sweep then runs many window settings with random gaps on
// both streams and pauses that let the unit drain.
// ----------------------------------------------------------------------------
module mandelbrot_dwell_unit_test;

  import mdw_pkg::*;

  localparam int    CYCLE_LIMIT   = 3_000_000;
  localparam longint PIXEL_RES_MAX = 4096;
  localparam longint Q_ONE         = 64'sd16777216;
  localparam logic [63:0] ESCAPE_Q48 = 64'd16 << 48;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [31:0]          cfg_wdata = '0;

  longint win_min_re = -58720256;
  longint win_min_im = -16777216;
  longint win_max_re = 8388608;
  longint win_max_im = 16777216;
  longint win_res    = 512;
  longint win_limit  = 514;

  logic [15:0] dwell_expected[$];
  logic [15:0] dwell_want;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          sink_hold = 0;
  int          sink_wait = 0;
  bit          gaps_on = 1'b1;

  mandelbrot_dwell_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mandelbrot_dwell_unit_test: done, errors");
      $finish;
    end
  end

  function automatic longint clamp_q32(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint effective_res();
    longint r;
    r = win_res;
    if (r < 1) r = 1;
    if (r > PIXEL_RES_MAX) r = PIXEL_RES_MAX;
    return r;
  endfunction

  function automatic longint map_pixel_axis(input logic [11:0] pix, input longint lo,
                                            input longint hi, input longint res);
    longint prod;
    longint q;
    prod = longint'(pix) * (hi - lo);
    if (prod >= 0) q = prod / res;
    else q = -((-prod + res - 1) / res);
    return clamp_q32(lo + q);
  endfunction

  function automatic logic [15:0] predict_dwell(input logic [11:0] col, input logic [11:0] row);
    longint      res;
    longint      c_re;
    longint      c_im;
    longint      re;
    longint      im;
    longint      rr;
    longint      ii;
    longint      ri;
    logic [63:0] mag;
    longint      n;
    res  = effective_res();
    c_re = map_pixel_axis(col, win_min_re, win_max_re, res);
    c_im = map_pixel_axis(row, win_min_im, win_max_im, res);
    re   = c_re;
    im   = c_im;
    n    = 0;
    while (n < win_limit) begin
      rr  = re * re;
      ii  = im * im;
      ri  = re * im;
      mag = $unsigned(rr) + $unsigned(ii);
      if (mag >= ESCAPE_Q48) break;
      re = clamp_q32(((rr - ii) >>> 24) + c_re);
      im = clamp_q32((ri >>> 23) + c_im);
      n++;
    end
    return n[15:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_CORNER_MIN_RE: win_min_re = longint'(signed'(value));
      REG_CORNER_MIN_IM: win_min_im = longint'(signed'(value));
      REG_CORNER_MAX_RE: win_max_re = longint'(signed'(value));
      REG_CORNER_MAX_IM: win_max_im = longint'(signed'(value));
      REG_RESOLUTION:    win_res    = longint'(value[12:0]);
      REG_DWELL_LIMIT:   win_limit  = longint'(value[15:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_window(input longint min_re, input longint min_im, input longint max_re,
                              input longint max_im, input longint res, input longint limit);
    write_reg(REG_CORNER_MIN_RE, min_re[31:0]);
    write_reg(REG_CORNER_MIN_IM, min_im[31:0]);
    write_reg(REG_CORNER_MAX_RE, max_re[31:0]);
    write_reg(REG_CORNER_MAX_IM, max_im[31:0]);
    write_reg(REG_RESOLUTION, res[31:0]);
    write_reg(REG_DWELL_LIMIT, limit[31:0]);
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {row, col};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    dwell_expected.push_back(predict_dwell(col, row));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (dwell_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        out_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (dwell_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected dwell beat: actual %0d", out_tdata);
      end else begin
        dwell_want = dwell_expected.pop_front();
        if (out_tdata !== dwell_want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("dwell mismatch: expected %0d, actual %0d", dwell_want, out_tdata);
          end
        end
      end
      sink_wait = gaps_on ? $urandom_range(0, 19) : 0;
    end
  end

  task automatic test_reset_window();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd384, 12'd256);
    send_pixel(12'd511, 12'd511);
    send_pixel(12'd4095, 12'd4095);
    wait_results_drained();
  endtask

  task automatic test_corner_extremes();
    write_window(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 1, 8);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    wait_results_drained();
    write_window(64'sd2147483647, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 3, 8);
    send_pixel(12'd2, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    wait_results_drained();
  endtask

  task automatic test_resolution_limits();
    write_window(-2 * Q_ONE, -(3 * Q_ONE) / 2, Q_ONE, (3 * Q_ONE) / 2, 0, 16);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    wait_results_drained();
    write_reg(REG_RESOLUTION, 32'd8191);
    send_pixel(12'd4095, 12'd2048);
    send_pixel(12'd100, 12'd4000);
    wait_results_drained();
    write_reg(REG_RESOLUTION, 32'd4096);
    send_pixel(12'd4095, 12'd4095);
    wait_results_drained();
  endtask

  task automatic test_dwell_limit_extremes();
    write_window(-58720256, -16777216, 8388608, 16777216, 512, 0);
    send_pixel(12'd384, 12'd256);
    wait_results_drained();
    write_reg(REG_DWELL_LIMIT, 32'd1);
    send_pixel(12'd384, 12'd256);
    wait_results_drained();
    write_reg(REG_DWELL_LIMIT, 32'd65535);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd448, 12'd256);
    wait_results_drained();
  endtask

  task automatic test_unused_index();
    write_reg(REG_DWELL_LIMIT, 32'd20);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    send_pixel(12'd300, 12'd200);
    send_pixel(12'd400, 12'd300);
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    int k;
    write_window(-2 * Q_ONE, -Q_ONE, Q_ONE, Q_ONE, 64, 4);
    sink_hold = 1500;
    for (k = 0; k < 10; k++) begin
      send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
    end
    wait_results_drained();
  endtask

  task automatic pick_random_setting();
    longint min_re;
    longint min_im;
    longint max_re;
    longint max_im;
    longint res;
    int     sel;
    if ($urandom_range(0, 9) == 0) begin
      min_re = longint'(signed'($urandom()));
      min_im = longint'(signed'($urandom()));
      max_re = longint'(signed'($urandom()));
      max_im = longint'(signed'($urandom()));
    end else begin
      min_re = -41943040 + longint'($urandom_range(0, 33554432));
      min_im = -25165824 + longint'($urandom_range(0, 25165824));
      max_re = min_re + longint'($urandom_range(1 << 16, 3 << 24));
      max_im = min_im + longint'($urandom_range(1 << 16, 3 << 24));
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) res = 0;
    else if (sel == 1) res = $urandom_range(4097, 8191);
    else if (sel == 2) res = 1;
    else res = $urandom_range(2, 4096);
    write_window(min_re, min_im, max_re, max_im, res, $urandom_range(0, 48));
  endtask

  task automatic test_random_sweep();
    int     phase;
    int     k;
    longint res;
    for (phase = 0; phase < 10; phase++) begin
      pick_random_setting();
      gaps_on = (phase != 3);
      res = effective_res();
      for (k = 0; k < 110; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end else begin
          send_pixel(12'($urandom_range(0, res - 1)), 12'($urandom_range(0, res - 1)));
        end
        if (k == 55 && phase % 2 == 1) wait_results_drained();
      end
      wait_results_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_window();
    test_corner_extremes();
    test_resolution_limits();
    test_dwell_limit_extremes();
    test_unused_index();
    test_output_backpressure();
    test_random_sweep();
    wait_results_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && dwell_expected.size() == 0) begin
      $display("mandelbrot_dwell_unit_test: done, clean");
    end else begin
      $display("mandelbrot_dwell_unit_test: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mdw_pkg.sv
sv/mdw_mul.sv
sv/mdw_div.sv
sv/mandelbrot_dwell_unit.sv
sv/mdw_checker.sv
tb/sv/mandelbrot_dwell_unit_test.sv
